### hw/rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W     = 16;
  localparam int AGE_W    = 7;
  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    status_t status;
    entry_t  ent;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PLACE,
    S_REM,
    S_DONE
  } state_t;

endpackage

### hw/rtl/spq_if.sv
// Request and result channel interfaces for the stable priority queue.
interface spq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [spq_pkg::ID_W-1:0]    patient_id;
  logic [spq_pkg::AGE_W-1:0]   age;
  logic [spq_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, output func, output patient_id, output age,
                  output priority_req, input ready);
  modport sink (input valid, input func, input patient_id, input age,
                input priority_req, output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::ID_W-1:0]      out_id;
  logic [spq_pkg::AGE_W-1:0]     out_age;
  logic [spq_pkg::PRIO_W-1:0]    out_priority;

  modport source (output valid, output status, output out_id, output out_age,
                  output out_priority, input ready);
  modport sink (input valid, input status, input out_id, input out_age,
                input out_priority, output ready);
endinterface

### hw/rtl/spq_store.sv
// Entry storage: one write port and one registered read port.
module spq_store #(
  parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  spq_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output spq_pkg::entry_t            rd_data
);

  spq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/stable_priority_queue_core.sv
// Top level of the stable priority queue: sequencer, storage and result register.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  in_ch    | in  | valid/ready  | func, patient_id, age, priority_req
//  out_ch   | out | valid/ready  | status, out_id, out_age, out_priority
//
// Sequencing: a refused insert, an insert into an empty queue or a remove on an
//   empty queue goes straight to the done state. Any other insert walks from
//   the tail toward its position; a remove walks every stored entry. The
//   storage walks one entry per cycle over its read and write ports, with the
//   priority comparator checked once per entry.
// Reset clears the sequencer, the occupancy and the result valid flag; stored
//   entries stay undefined and are never read before being written.
// A stalled result holds in the output register; the next request is taken
//   meanwhile and waits in its last step until the register frees up.
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::state_t state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;      // index of the entry whose read data arrives
  spq_pkg::entry_t  new_r, new_nxt;      // entry being inserted
  spq_pkg::res_t    res_r, res_nxt;      // result under construction

  logic             out_valid_r;
  spq_pkg::res_t    out_r;

  // storage port controls
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  spq_pkg::entry_t  wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  spq_pkg::entry_t  rd_data;

  logic             accept;
  logic             out_load;
  logic             out_free;
  logic             cmp_gt;              // shared comparator: stored prio above new prio
  logic [OCC_W-1:0] occ_dec;
  logic [IDX_W-1:0] last_idx;
  spq_pkg::entry_t  in_entry;

  assign in_ch.ready = (state_r == spq_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign in_entry.id   = in_ch.patient_id;
  assign in_entry.age  = in_ch.age;
  assign in_entry.prio = in_ch.priority_req;

  assign occ_dec  = occ_r - OCC_W'(1);
  assign last_idx = occ_dec[IDX_W-1:0];
  assign cmp_gt   = rd_data.prio > new_r.prio;

  spq_store #(
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.func == spq_pkg::FUNC_INSERT) begin
            if (occ_r == OCC_W'(QUEUE_DEPTH) || occ_r == '0) begin
              state_nxt = spq_pkg::S_DONE;
            end else begin
              state_nxt = spq_pkg::S_INS;
            end
          end else begin
            state_nxt = (occ_r == '0) ? spq_pkg::S_DONE : spq_pkg::S_REM;
          end
        end
      end
      spq_pkg::S_INS: begin
        if (!cmp_gt) begin
          state_nxt = spq_pkg::S_DONE;
        end else if (idx_r == '0) begin
          state_nxt = spq_pkg::S_PLACE;
        end
      end
      spq_pkg::S_PLACE: begin
        state_nxt = spq_pkg::S_DONE;
      end
      spq_pkg::S_REM: begin
        if (OCC_W'(idx_r) == occ_dec) begin
          state_nxt = spq_pkg::S_DONE;
        end
      end
      spq_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  // Datapath and storage controls
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = new_r;
    rd_en    = 1'b0;
    rd_addr  = '0;
    idx_nxt  = idx_r;
    occ_nxt  = occ_r;
    new_nxt  = new_r;
    res_nxt  = res_r;
    out_load = 1'b0;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          new_nxt        = in_entry;
          res_nxt        = '0;
          res_nxt.status = spq_pkg::ST_INSERTED;
          if (in_ch.func == spq_pkg::FUNC_INSERT) begin
            if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
              res_nxt.status = spq_pkg::ST_FULL;
            end else if (occ_r == '0) begin
              wr_en   = 1'b1;
              wr_data = in_entry;
              occ_nxt = occ_r + OCC_W'(1);
            end else begin
              // walk from the tail toward the head
              rd_en   = 1'b1;
              rd_addr = last_idx;
              idx_nxt = last_idx;
            end
          end else begin
            if (occ_r == '0) begin
              res_nxt.status = spq_pkg::ST_EMPTY;
            end else begin
              rd_en   = 1'b1;
              idx_nxt = '0;
            end
          end
        end
      end
      spq_pkg::S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + IDX_W'(1);
        if (cmp_gt) begin
          // larger key moves back one slot
          wr_data = rd_data;
          if (idx_r != '0) begin
            rd_en   = 1'b1;
            rd_addr = idx_r - IDX_W'(1);
            idx_nxt = idx_r - IDX_W'(1);
          end
        end else begin
          // equal or smaller key stays ahead: new entry lands behind it
          wr_data = new_r;
          occ_nxt = occ_r + OCC_W'(1);
        end
      end
      spq_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_data = new_r;
        occ_nxt = occ_r + OCC_W'(1);
      end
      spq_pkg::S_REM: begin
        if (idx_r == '0) begin
          res_nxt.status = spq_pkg::ST_REMOVED;
          res_nxt.ent    = rd_data;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_r - IDX_W'(1);
          wr_data = rd_data;
        end
        if (OCC_W'(idx_r) == occ_dec) begin
          occ_nxt = occ_dec;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + IDX_W'(1);
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      spq_pkg::S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    new_r <= new_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.out_id       = out_r.ent.id;
  assign out_ch.out_age      = out_r.ent.age;
  assign out_ch.out_priority = out_r.ent.prio;

  // Occupancy never passes the depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  // A refused insert leaves the queue untouched.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.func == spq_pkg::FUNC_INSERT && occ_r == OCC_W'(QUEUE_DEPTH)
    |=> occ_r == $past(occ_r) && res_r.status == spq_pkg::ST_FULL)
    else $error("full insert changed the queue");

  // An empty report only leaves with an empty queue.
  a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_r.status == spq_pkg::ST_EMPTY |-> occ_r == '0)
    else $error("empty status with entries stored");

  // The walk only reads occupied slots.
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::S_INS || state_r == spq_pkg::S_REM)
    |-> OCC_W'(idx_r) < occ_r)
    else $error("walk index beyond occupancy");

  // A reported removal sees the occupancy unchanged from the last cycle or below the depth.
  a_rem_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_r.status == spq_pkg::ST_REMOVED
    |-> occ_r == $past(occ_r) || occ_r < OCC_W'(QUEUE_DEPTH))
    else $error("removal left queue full");

endmodule
